@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and defaults of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int COORD_BITS_DEFAULT = 10;
   localparam int COST_BITS          = 14;

   typedef enum logic [1:0] {
      KIND_ENQUEUE  = 2'd0,
      KIND_DEQUEUE  = 2'd1,
      KIND_REMOVE   = 2'd2,
      KIND_CONTAINS = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RD_HERE  = 2'd0,
      RD_BELOW = 2'd1,
      RD_ABOVE = 2'd2
   } rd_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_ENQ_CHECK,
      ST_ENQ_EVAL,
      ST_SCAN_RD,
      ST_SCAN_EVAL,
      ST_SHIFT_EVAL,
      ST_SHIFT_WR,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       latch_req;
      logic       idx_to_count;
      logic       idx_clear;
      logic       idx_inc;
      logic       idx_dec;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       wr_new;
      logic       capture_out;
      logic       set_found;
      logic       status_we;
      status_type status_val;
      logic       count_inc;
      logic       count_dec;
      logic       load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     empty;
      logic     full;
      logic     idx_zero;
      logic     idx_last;
      logic     cost_ge;
      logic     coord_match;
      logic     rsp_busy;
   } stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/spq_ram.sv @@
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: walks the entry memory for insert, scan and shift-down.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl
   import spq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   logic scan_hit;
   assign scan_hit = (stat.kind == KIND_DEQUEUE) || stat.coord_match;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            case (stat.kind)
               KIND_ENQUEUE: begin
                  state_in = stat.full ? ST_IDLE : ST_ENQ_CHECK;
                  if (stat.full && stat.rsp_busy) begin
                     state_in = ST_START;
                  end
               end
               default: begin
                  state_in = stat.empty ? ST_IDLE : ST_SCAN_RD;
                  if (stat.empty && stat.rsp_busy) begin
                     state_in = ST_START;
                  end
               end
            endcase
         end
         ST_ENQ_CHECK: begin
            if (stat.idx_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_ENQ_EVAL;
            end
         end
         ST_ENQ_EVAL: begin
            state_in = stat.cost_ge ? ST_ENQ_CHECK : ST_FINISH;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_EVAL;
         end
         ST_SCAN_EVAL: begin
            if (scan_hit) begin
               state_in = (stat.kind == KIND_CONTAINS) ? ST_FINISH : ST_SHIFT_EVAL;
            end else if (stat.idx_last) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SHIFT_EVAL: begin
            if (stat.idx_last) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            state_in = ST_SHIFT_EVAL;
         end
         ST_FINISH: begin
            // Hold here until the result register frees
            if (!stat.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.latch_req = req_valid;
         end
         ST_START: begin
            case (stat.kind)
               KIND_ENQUEUE: begin
                  if (stat.full) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_val = STAT_FULL;
                     cmd.load_rsp   = !stat.rsp_busy;
                  end else begin
                     cmd.idx_to_count = 1'b1;
                  end
               end
               default: begin
                  cmd.idx_clear = 1'b1;
                  if (stat.empty) begin
                     cmd.status_we  = (stat.kind != KIND_CONTAINS);
                     cmd.status_val = (stat.kind == KIND_DEQUEUE) ? STAT_EMPTY
                                                                  : STAT_NOT_FOUND;
                     cmd.load_rsp   = !stat.rsp_busy;
                  end
               end
            endcase
         end
         ST_ENQ_CHECK: begin
            if (stat.idx_zero) begin
               cmd.wr_en     = 1'b1;
               cmd.wr_new    = 1'b1;
               cmd.count_inc = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_BELOW;
            end
         end
         ST_ENQ_EVAL: begin
            cmd.wr_en = 1'b1;
            if (stat.cost_ge) begin
               cmd.idx_dec = 1'b1;
            end else begin
               cmd.wr_new    = 1'b1;
               cmd.count_inc = 1'b1;
            end
         end
         ST_SCAN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_HERE;
         end
         ST_SCAN_EVAL: begin
            if (scan_hit) begin
               cmd.capture_out = (stat.kind == KIND_DEQUEUE);
               cmd.set_found   = (stat.kind != KIND_DEQUEUE);
            end else if (stat.idx_last) begin
               cmd.status_we  = (stat.kind == KIND_REMOVE);
               cmd.status_val = STAT_NOT_FOUND;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_SHIFT_EVAL: begin
            // Hole at idx: close it by pulling up the entry above, or drop one
            if (stat.idx_last) begin
               cmd.count_dec = 1'b1;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ABOVE;
            end
         end
         ST_SHIFT_WR: begin
            // Move the entry read from above into the hole, advance the hole
            cmd.wr_en   = 1'b1;
            cmd.idx_inc = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_rsp = !stat.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// spq_datapath
// Request latch, entry memory, index and count, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [1:0]                 req_kind,
   input  wire logic [COORD_BITS-1:0]      req_item_x,
   input  wire logic [COORD_BITS-1:0]      req_item_y,
   input  wire logic [COST_BITS-1:0]       req_item_cost,
   input  wire cmd_type                    cmd,
   output stat_type                        stat,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [COORD_BITS-1:0]           rsp_out_x,
   output logic [COORD_BITS-1:0]           rsp_out_y,
   output logic [COST_BITS-1:0]            rsp_out_cost,
   output logic                            rsp_found,
   output logic [1:0]                      rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_occupancy
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = 2 * COORD_BITS + COST_BITS;

   // Request latch
   kind_type              kind_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic [COST_BITS-1:0]  cost_ff;

   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;

   logic [COORD_BITS-1:0] res_x_ff, res_x_in;
   logic [COORD_BITS-1:0] res_y_ff, res_y_in;
   logic [COST_BITS-1:0]  res_cost_ff, res_cost_in;
   logic                  res_found_ff, res_found_in;
   status_type            res_status_ff, res_status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff;
   logic [COORD_BITS-1:0] rsp_y_ff;
   logic [COST_BITS-1:0]  rsp_cost_ff;
   logic                  rsp_found_ff;
   status_type            rsp_status_ff;
   logic [CW-1:0]         rsp_occ_ff;

   // Entry memory
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] wr_data;
   logic [EW-1:0] rd_data;

   logic [COORD_BITS-1:0] rd_x;
   logic [COORD_BITS-1:0] rd_y;
   logic [COST_BITS-1:0]  rd_cost;

   assign rd_x    = rd_data[EW-1 -: COORD_BITS];
   assign rd_y    = rd_data[COST_BITS +: COORD_BITS];
   assign rd_cost = rd_data[COST_BITS-1:0];

   always_comb begin
      case (cmd.rd_sel)
         RD_BELOW: rd_addr = idx_ff - AW'(1);
         RD_ABOVE: rd_addr = idx_ff + AW'(1);
         default:  rd_addr = idx_ff;
      endcase
   end

   assign wr_data = cmd.wr_new ? {x_ff, y_ff, cost_ff} : rd_data;

   spq_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Index and count
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_to_count) begin
         idx_in = AW'(count_ff);
      end else if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - AW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Working result
   always_comb begin
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_cost_in   = res_cost_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      if (cmd.latch_req) begin
         res_x_in      = '0;
         res_y_in      = '0;
         res_cost_in   = '0;
         res_found_in  = 1'b0;
         res_status_in = STAT_OK;
      end else begin
         if (cmd.capture_out) begin
            res_x_in    = rd_x;
            res_y_in    = rd_y;
            res_cost_in = rd_cost;
         end
         if (cmd.set_found) begin
            res_found_in = 1'b1;
         end
         if (cmd.status_we) begin
            res_status_in = cmd.status_val;
         end
      end
   end

   // Result register: load takes the final count, so status paths that
   // load in the same cycle as a status write use the written code
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff <= kind_type'(req_kind);
         x_ff    <= req_item_x;
         y_ff    <= req_item_y;
         cost_ff <= req_item_cost;
      end
      idx_ff        <= idx_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_cost_ff   <= res_cost_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      if (cmd.load_rsp) begin
         rsp_x_ff      <= res_x_in;
         rsp_y_ff      <= res_y_in;
         rsp_cost_ff   <= res_cost_in;
         rsp_found_ff  <= res_found_in;
         rsp_status_ff <= res_status_in;
         rsp_occ_ff    <= count_in;
      end
   end

   // Status to the controller
   assign stat.kind        = kind_ff;
   assign stat.empty       = (count_ff == '0);
   assign stat.full        = (count_ff == CW'(DEPTH));
   assign stat.idx_zero    = (idx_ff == '0);
   assign stat.idx_last    = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign stat.cost_ge     = (rd_cost >= cost_ff);
   assign stat.coord_match = (rd_x == x_ff) && (rd_y == y_ff);
   assign stat.rsp_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_cost  = rsp_cost_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_no_insert_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> !stat.full)
      else $error("insert into full store");

   a_no_drop_when_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.count_dec |-> !stat.empty)
      else $error("drop from empty store");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (CW'(idx_ff) <= count_ff))
      else $error("write beyond filled region");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !stat.rsp_busy)
      else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Keeps up to DEPTH grid entries (x, y, cost) in ascending cost order in a
// single-port-read entry RAM. Kinds: enqueue (inserted ahead of every entry
// of equal or greater cost, so equal costs leave newest first), dequeue (pops
// the lowest cost), remove (deletes the first entry with matching
// coordinates) and contains (reports a coordinate match). Every request gives
// one response word with status (ok, full, empty, not found) and the count
// after the operation. One request is worked at a time; the RAM read is
// registered, so the sequencer reads each entry it visits and evaluates it
// in a separate state. An enqueue walks down from the tail and moves up
// each entry of equal or greater cost; dequeue and remove scan from the
// front up to the hit and then pull every entry above it down; contains and
// a remove that misses only scan; an enqueue into a full store and any other
// kind on an empty store answer without touching the RAM. A finished
// response sits in an output register; while an earlier word there is still
// unaccepted the sequencer holds, and the request side reopens in the cycle
// after the load.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_kind,
   input  wire logic [COORD_BITS-1:0] req_item_x,
   input  wire logic [COORD_BITS-1:0] req_item_y,
   input  wire logic [COST_BITS-1:0]  req_item_cost,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [COORD_BITS-1:0]      rsp_out_x,
   output logic [COORD_BITS-1:0]      rsp_out_y,
   output logic [COST_BITS-1:0]       rsp_out_cost,
   output logic                       rsp_found,
   output logic [1:0]                 rsp_status,
   output logic [$clog2(DEPTH+1)-1:0] rsp_occupancy
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer: decide per kind, walk the RAM, hold until the response frees
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: latch the word, move entries, build the response word
   spq_datapath #(
      .DEPTH      (DEPTH),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_kind      (req_kind),
      .req_item_x    (req_item_x),
      .req_item_y    (req_item_y),
      .req_item_cost (req_item_cost),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_cost  (rsp_out_cost),
      .rsp_found     (rsp_found),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

`default_nettype wire
